// ----- hdl/cvh_pkg.sv -----
// Types and constants shared by the convex hull block.
package cvh_pkg;

  localparam int COORD_BITS = 16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         end_of_hull;
    logic                         overflow;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } coord_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } turn_t;

endpackage

// ----- hdl/cvh_turn.sv -----
// Turn sign of three points from registered cross products.
module cvh_turn (
  input  logic           clk_i,
  input  cvh_pkg::coord_t a_i,
  input  cvh_pkg::coord_t b_i,
  input  cvh_pkg::coord_t c_i,
  output cvh_pkg::turn_t  turn_o
);
  import cvh_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] bax, bay, cax, cay;
  logic signed [PW-1:0] l_q, r_q;

  assign bax = DW'(b_i.x) - DW'(a_i.x);
  assign bay = DW'(b_i.y) - DW'(a_i.y);
  assign cax = DW'(c_i.x) - DW'(a_i.x);
  assign cay = DW'(c_i.y) - DW'(a_i.y);

  always_ff @(posedge clk_i) begin
    l_q <= bax * cay;
    r_q <= bay * cax;
  end

  assign turn_o.pos = l_q > r_q;
  assign turn_o.neg = l_q < r_q;

endmodule

// ----- hdl/convex_hull_monotone_chain_top.sv -----
// Convex hull by the monotone chain rule over a loaded point set.
//
// Input: a point transfers when start is high and busy is low. Points are
// stored in arrival order, up to MAX_POINTS; later ones are dropped and the
// run is flagged with overflow. A point with final_point set ends the set
// and starts the hull pass; busy stays high until the run is out.
// Loading takes one cycle per point.
// Hull pass: insertion sort on the point memory, with a fetch of each point
// and a compare step for each shift, a dedup sweep over the points, and the
// chain pass: each point is fetched, turn tested against both chains and
// pushed, with a chain check before each turn test that skips it when the
// chain holds fewer than two entries; the pace is set by the single read port
// of the point and chain memories and the shared registered cross product unit.
// Output: each vertex sits on vertex for one cycle with strobe high, lower
// chain first, then the upper chain reversed without its endpoints;
// end_of_hull marks the last. The receiver cannot stall. Reset clears the
// count, the flag and the controller; the memories keep whatever they held.
module convex_hull_monotone_chain_top #(
  parameter int MAX_POINTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cvh_pkg::point_t  point_i,
  output logic             strobe,
  output cvh_pkg::vertex_t vertex_o
);
  import cvh_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int OW = CW + 1;

  typedef enum logic [17:0] {
    S_IDLE = 18'd1,      S_SRDI = 18'd2,      S_SGET = 18'd4,
    S_SRDK = 18'd8,      S_SCMP = 18'd16,     S_DRD  = 18'd32,
    S_DCHK = 18'd64,     S_CRD  = 18'd128,    S_CGET = 18'd256,
    S_UCHK = 18'd512,    S_UMUL = 18'd1024,   S_UCMP = 18'd2048,
    S_LCHK = 18'd4096,   S_LMUL = 18'd8192,   S_LCMP = 18'd16384,
    S_PUSH = 18'd32768,  S_ORD  = 18'd65536,  S_OEM  = 18'd131072
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, k_q, k_d;
  logic [CW-1:0] us_q, us_d, ls_q, ls_d;
  logic [OW-1:0] o_q, o_d, tot_q, tot_d;
  logic          drop_q, drop_d, osel_q, osel_d;
  coord_t        v_q, v_d, c_q, c_d, last_q, last_d, a_q, a_d;
  coord_t        ut_q, ut_d, lt_q, lt_d;

  coord_t        s_mem [MAX_POINTS];
  coord_t        u_mem [MAX_POINTS];
  coord_t        l_mem [MAX_POINTS];
  logic          s_we, u_we, l_we;
  logic [IW-1:0] s_wa, s_ra, u_ra, l_ra;
  coord_t        s_wd, s_rd_q, u_rd_q, l_rd_q;

  coord_t        ta, tb;
  turn_t         turn;
  coord_t        inp;
  logic          v_lt;
  logic [OW-1:0] uidx;

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_wa] <= s_wd;
    end
    if (u_we) begin
      u_mem[us_q[IW-1:0]] <= c_q;
    end
    if (l_we) begin
      l_mem[ls_q[IW-1:0]] <= c_q;
    end
    s_rd_q <= s_mem[s_ra];
    u_rd_q <= u_mem[u_ra];
    l_rd_q <= l_mem[l_ra];
  end

  assign ta = (state_q == S_UMUL) ? u_rd_q : l_rd_q;
  assign tb = (state_q == S_UMUL) ? ut_q : lt_q;

  cvh_turn u_turn (
    .clk_i  (clk_i),
    .a_i    (ta),
    .b_i    (tb),
    .c_i    (c_q),
    .turn_o (turn)
  );

  assign inp.x  = point_i.point_x;
  assign inp.y  = point_i.point_y;
  assign v_lt   = (v_q.y < s_rd_q.y) || ((v_q.y == s_rd_q.y) && (v_q.x < s_rd_q.x));
  assign uidx   = OW'(us_q) - OW'(2) - (o_q - OW'(ls_q));

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;  n_d = n_q;  i_d = i_q;  k_d = k_q;
    us_d = us_q;  ls_d = ls_q;  o_d = o_q;  tot_d = tot_q;
    drop_d = drop_q;  osel_d = osel_q;
    v_d = v_q;  c_d = c_q;  last_d = last_q;  a_d = a_q;
    ut_d = ut_q;  lt_d = lt_q;
    s_we = 1'b0;  s_wa = k_q[IW-1:0];  s_wd = v_q;  s_ra = i_q[IW-1:0];
    u_we = 1'b0;  l_we = 1'b0;
    u_ra = IW'(us_q - CW'(2));
    l_ra = IW'(ls_q - CW'(2));
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cnt_q < CW'(MAX_POINTS)) begin
            s_we  = 1'b1;
            s_wa  = cnt_q[IW-1:0];
            s_wd  = inp;
            cnt_d = cnt_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (point_i.final_point) begin
            n_d = cnt_d;
            k_d = '0;
            if (cnt_d > CW'(1)) begin
              i_d = CW'(1);
              state_d = S_SRDI;
            end else begin
              i_d = '0;
              state_d = S_DRD;
            end
          end
        end
      end
      S_SRDI: state_d = S_SGET;
      S_SGET: begin
        v_d = s_rd_q;
        k_d = i_q;
        state_d = S_SRDK;
      end
      S_SRDK, S_SCMP: begin
        s_ra = IW'(k_q - CW'(1));
        if (state_q == S_SRDK && k_q != '0) begin
          state_d = S_SCMP;
        end else if (state_q == S_SCMP && v_lt) begin
          s_we = 1'b1;
          s_wd = s_rd_q;
          k_d = k_q - CW'(1);
          state_d = S_SRDK;
        end else begin
          s_we = 1'b1;
          i_d = i_q + CW'(1);
          if (i_q + CW'(1) < n_q) begin
            state_d = S_SRDI;
          end else begin
            i_d = '0;
            k_d = '0;
            state_d = S_DRD;
          end
        end
      end
      S_DRD: state_d = S_DCHK;
      S_DCHK: begin
        if (k_q == '0 || s_rd_q != last_q) begin
          s_we = 1'b1;
          s_wd = s_rd_q;
          last_d = s_rd_q;
          k_d = k_q + CW'(1);
        end
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) < n_q) begin
          state_d = S_DRD;
        end else begin
          n_d = k_d;
          i_d = '0;
          us_d = '0;
          ls_d = '0;
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CGET;
      S_CGET: begin
        c_d = s_rd_q;
        state_d = S_UCHK;
      end
      S_UCHK: state_d = (us_q > CW'(1)) ? S_UMUL : S_LCHK;
      S_UMUL: begin
        a_d = u_rd_q;
        state_d = S_UCMP;
      end
      S_UCMP: begin
        if (!turn.neg) begin
          us_d = us_q - CW'(1);
          ut_d = a_q;
          state_d = S_UCHK;
        end else begin
          state_d = S_LCHK;
        end
      end
      S_LCHK: state_d = (ls_q > CW'(1)) ? S_LMUL : S_PUSH;
      S_LMUL: begin
        a_d = l_rd_q;
        state_d = S_LCMP;
      end
      S_LCMP: begin
        if (!turn.pos) begin
          ls_d = ls_q - CW'(1);
          lt_d = a_q;
          state_d = S_LCHK;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        u_we = 1'b1;
        l_we = 1'b1;
        ut_d = c_q;
        lt_d = c_q;
        us_d = us_q + CW'(1);
        ls_d = ls_q + CW'(1);
        i_d = i_q + CW'(1);
        if (i_q + CW'(1) < n_q) begin
          state_d = S_CRD;
        end else begin
          tot_d = OW'(ls_d) + ((us_d >= CW'(2)) ? OW'(us_d) - OW'(2) : '0);
          o_d = '0;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        l_ra = o_q[IW-1:0];
        u_ra = uidx[IW-1:0];
        osel_d = (o_q >= OW'(ls_q));
        state_d = S_OEM;
      end
      S_OEM: begin
        o_d = o_q + OW'(1);
        if (o_q + OW'(1) == tot_q) begin
          cnt_d = '0;
          drop_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      n_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      us_q    <= '0;
      ls_q    <= '0;
      o_q     <= '0;
      tot_q   <= '0;
      osel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      n_q     <= n_d;
      i_q     <= i_d;
      k_q     <= k_d;
      us_q    <= us_d;
      ls_q    <= ls_d;
      o_q     <= o_d;
      tot_q   <= tot_d;
      osel_q  <= osel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    c_q    <= c_d;
    last_q <= last_d;
    a_q    <= a_d;
    ut_q   <= ut_d;
    lt_q   <= lt_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign strobe = (state_q == S_OEM);
  assign vertex_o.vertex_x    = osel_q ? u_rd_q.x : l_rd_q.x;
  assign vertex_o.vertex_y    = osel_q ? u_rd_q.y : l_rd_q.y;
  assign vertex_o.end_of_hull = (o_q + OW'(1) == tot_q);
  assign vertex_o.overflow    = drop_q;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("vertex transfer while idle");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && vertex_o.end_of_hull) |=> !busy) else $error("run did not end");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS)) else $error("point count out of range");
  a_chain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (us_q <= CW'(MAX_POINTS)) && (ls_q <= CW'(MAX_POINTS)))
    else $error("chain size out of range");

endmodule

// ----- test/convex_hull_monotone_chain_top_tb.sv -----
// Testbench for the convex hull block: predicts hull vertex runs and checks each one.
`timescale 1ns / 1ps

module convex_hull_monotone_chain_top_tb;
  import cvh_pkg::*;

  localparam int MAXP = 16;
  localparam int WATCH_LIMIT = 20000;

  class hull_board;
    coord_t pts[$];
    bit dropped;
    vertex_t hull_q[$];
    int errors;

    function bit lt(coord_t a, coord_t b);
      return (a.y < b.y) || (a.y == b.y && a.x < b.x);
    endfunction

    function longint area2(coord_t a, coord_t b, coord_t c);
      longint l, r;
      l = (longint'(b.x) - a.x) * (longint'(c.y) - a.y);
      r = (longint'(b.y) - a.y) * (longint'(c.x) - a.x);
      return l - r;
    endfunction

    function void note_point(point_t p);
      coord_t c, s[$], lo[$], up[$], v, t;
      int total, k;
      c.x = p.point_x;
      c.y = p.point_y;
      if (pts.size() < MAXP) pts.insert(pts.size(), c);
      else dropped = 1;
      if (!p.final_point) return;
      for (int i = 1; i < pts.size(); i++) begin
        t = pts[i];
        k = i;
        while (k > 0 && lt(t, pts[k-1])) begin
          pts[k] = pts[k-1];
          k--;
        end
        pts[k] = t;
      end
      foreach (pts[i])
        if (s.size() == 0 || pts[i] != s[s.size()-1]) s.insert(s.size(), pts[i]);
      foreach (s[i]) begin
        while (up.size() > 1 && area2(up[up.size()-2], up[up.size()-1], s[i]) >= 0)
          up.delete(up.size() - 1);
        while (lo.size() > 1 && area2(lo[lo.size()-2], lo[lo.size()-1], s[i]) <= 0)
          lo.delete(lo.size() - 1);
        up.insert(up.size(), s[i]);
        lo.insert(lo.size(), s[i]);
      end
      total = lo.size() + (up.size() >= 2 ? up.size() - 2 : 0);
      for (int i = 0; i < total; i++) begin
        vertex_t e;
        v = (i < lo.size()) ? lo[i] : up[up.size() - 2 - (i - lo.size())];
        e.vertex_x = v.x;
        e.vertex_y = v.y;
        e.end_of_hull = (i + 1 == total);
        e.overflow = dropped;
        hull_q.insert(hull_q.size(), e);
      end
      pts.delete();
      dropped = 0;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (hull_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex: exp none got %h", got);
        return;
      end
      e = hull_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("vertex mismatch: exp x=%0d y=%0d end=%b ovf=%b got x=%0d y=%0d end=%b ovf=%b",
                   e.vertex_x, e.vertex_y, e.end_of_hull, e.overflow,
                   got.vertex_x, got.vertex_y, got.end_of_hull, got.overflow);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0, start = 0;
  logic busy, strobe;
  point_t point_i = '0;
  vertex_t vertex_o;
  hull_board board = new();
  int idle_pct = 0;
  int quiet = 0;

  convex_hull_monotone_chain_top uut (
    .clk_i, .rst_ni, .start, .busy, .point_i, .strobe, .vertex_o
  );

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe) board.check_vertex(vertex_o);
      if ((start && !busy) || strobe) quiet <= 0;
      else quiet <= quiet + 1;
    end
  end

  always @(posedge clk_i)
    if (quiet >= WATCH_LIMIT) begin
      $display("FAIL convex_hull_monotone_chain_top");
      $finish;
    end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit fin);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.final_point = fin;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    point_i <= p;
    do @(posedge clk_i); while (busy);
    board.note_point(p);
  endtask

  function automatic logic signed [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(7) - 4);
      1: return 16'($urandom);
      default: return 16'(($urandom_range(1) ? 16'sh7fff : -16'sh8000) - $urandom_range(1));
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++) send_point(rnd_coord(mode), rnd_coord(mode), i == n - 1);
  endtask

  initial begin
    int sent, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_point(5, -3, 1);
    send_point(1, 1, 0); send_point(1, 1, 1);
    send_point(32767, 32767, 0); send_point(-32768, -32768, 1);
    send_point(0, 0, 0); send_point(1, 1, 0); send_point(2, 2, 1);
    send_point(-32768, -32768, 0); send_point(32767, -32768, 0);
    send_point(32767, 32767, 0); send_point(-32768, 32767, 0);
    send_point(0, 0, 1);
    for (int i = 0; i < 18; i++) send_point(16'(i - 9), 16'((i * 7) % 11), i == 17);
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 85 : (ph == 3) ? 8 : 0;
      while (sent < 45 * (ph + 1)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
        send_set(n, $urandom_range(2));
        sent += n;
      end
    end
    start <= 0;
    while (board.hull_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) $display("PASS convex_hull_monotone_chain_top");
    else $display("FAIL convex_hull_monotone_chain_top");
    $finish;
  end
endmodule
